// ----- rtl/mbtf_pkg.sv -----
// Package for the MP4 box type filter.
// Holds the parse phase and status codes, the result batch type and register indexes.
// No dependencies.
package mbtf_pkg;

    // Header length in bytes: 32-bit size then 32-bit type
    localparam int unsigned HDR_BYTES = 8;

    // Reset drop types: "ftyp" and "moov"
    localparam logic [31:0] TYPE_FTYP = 32'h6674_7970;
    localparam logic [31:0] TYPE_MOOV = 32'h6d6f_6f76;

    // Configuration register indexes
    localparam logic CFG_DROP_FIRST  = 1'b0;
    localparam logic CFG_DROP_SECOND = 1'b1;

    // Parse phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_STOP   = 3'b100
    } phase_t;

    // Packet status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TRUNC_HEADER = 2'd1,
        ST_TRUNC_BODY   = 2'd2,
        ST_SMALL_SIZE   = 2'd3
    } status_t;

    // Results caused by one input byte: a header burst or one body byte,
    // optionally followed by a status item
    typedef struct packed {
        logic        hdr_valid;
        logic [63:0] hdr;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        stat_valid;
        status_t     stat;
    } batch_t;

endpackage

// ----- rtl/mbtf_parser.sv -----
// Box header parser: drop type registers, per-packet parse state and batch generation.
// Depends on mbtf_pkg.
module mbtf_parser
    import mbtf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        end_of_packet,
    output logic        push,
    output batch_t      batch
);

    logic [31:0] drop_first_reg;
    logic [31:0] drop_second_reg;

    phase_t      phase_reg, phase_next;
    logic [55:0] hold_reg, hold_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] body_reg, body_next;
    logic        keep_reg, keep_next;
    status_t     err_reg, err_next;

    logic [63:0] hold_full;
    logic [31:0] box_size;
    logic [31:0] box_type;

    // Drop type registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_first_reg  <= TYPE_FTYP;
            drop_second_reg <= TYPE_MOOV;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DROP_FIRST)
                drop_first_reg <= cfg_data;
            else if (cfg_index == CFG_DROP_SECOND)
                drop_second_reg <= cfg_data;
        end
    end

    // Next parse state and the results of this byte
    always_comb
    begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        count_next = count_reg;
        body_next  = body_reg;
        keep_next  = keep_reg;
        err_next   = err_reg;
        batch      = '0;
        hold_full  = {hold_reg, in_byte};
        box_size   = hold_full[63:32];
        box_type   = hold_full[31:0];

        case (phase_reg)
            PH_HEADER:
            begin
                count_next = count_reg + 3'd1;
                hold_next  = hold_full[55:0];
                // eighth header byte: decide on the box
                if (count_reg == 3'(HDR_BYTES - 1))
                begin
                    count_next = '0;
                    hold_next  = '0;
                    if (box_size < 32'(HDR_BYTES))
                    begin
                        err_next   = ST_SMALL_SIZE;
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        keep_next       = (box_type != drop_first_reg) &&
                                          (box_type != drop_second_reg);
                        batch.hdr_valid = keep_next;
                        batch.hdr       = hold_full;
                        body_next       = box_size - 32'(HDR_BYTES);
                        phase_next      = (body_next != '0) ? PH_BODY : PH_HEADER;
                    end
                end
                if (end_of_packet && err_next == ST_OK)
                begin
                    if (phase_next == PH_HEADER && count_next != '0)
                        err_next = ST_TRUNC_HEADER;
                    else if (phase_next == PH_BODY)
                        err_next = ST_TRUNC_BODY;
                end
            end
            PH_BODY:
            begin
                batch.data_valid = keep_reg;
                batch.data_byte  = in_byte;
                body_next        = body_reg - 32'd1;
                if (body_next == '0)
                    phase_next = PH_HEADER;
                else if (end_of_packet && err_reg == ST_OK)
                    err_next = ST_TRUNC_BODY;
            end
            default: ; // stopped: byte swallowed
        endcase

        // end of packet: status item and restart
        if (end_of_packet)
        begin
            batch.stat_valid = 1'b1;
            batch.stat       = err_next;
            phase_next       = PH_HEADER;
            hold_next        = '0;
            count_next       = '0;
            body_next        = '0;
            keep_next        = 1'b0;
            err_next         = ST_OK;
        end
    end

    assign push = accept && (batch.hdr_valid || batch.data_valid || batch.stat_valid);

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hold_reg  <= '0;
            count_reg <= '0;
            body_reg  <= '0;
            keep_reg  <= 1'b0;
            err_reg   <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            count_reg <= count_next;
            body_reg  <= body_next;
            keep_reg  <= keep_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ----- rtl/mbtf_emitter.sv -----
// Result emitter: one-batch holding slot and a serialiser onto the output stream.
// Depends on mbtf_pkg.
module mbtf_emitter
    import mbtf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  batch_t      batch,
    output logic        slot_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    batch_t      slot_reg;
    logic        slot_valid_reg;
    batch_t      cur_reg;
    logic        cur_valid_reg;
    logic [3:0]  idx_reg;

    logic [3:0]  data_items;
    logic [3:0]  total_items;
    logic        cur_last;
    logic        is_data;
    logic [63:0] hdr_shift;
    logic [7:0]  item_byte;
    logic        item_first;
    status_t     item_stat;
    logic        done;
    logic        slot_pop;

    // Item count and position in the current batch
    assign data_items  = cur_reg.hdr_valid ? 4'(HDR_BYTES) :
                         (cur_reg.data_valid ? 4'd1 : 4'd0);
    assign total_items = data_items + {3'd0, cur_reg.stat_valid};
    assign cur_last    = (idx_reg == total_items - 4'd1);
    assign is_data     = (idx_reg < data_items);

    // Header bytes go out most significant first
    assign hdr_shift  = cur_reg.hdr << {idx_reg[2:0], 3'b000};
    assign item_byte  = !is_data ? 8'd0 :
                        (cur_reg.hdr_valid ? hdr_shift[63:56] : cur_reg.data_byte);
    assign item_first = is_data && cur_reg.hdr_valid && (idx_reg == '0);
    assign item_stat  = is_data ? ST_OK : cur_reg.stat;

    assign m_tvalid = cur_valid_reg;
    assign m_tdata  = {5'd0, item_stat, item_first, item_byte};
    assign m_tuser  = !is_data;
    assign m_tlast  = cur_last;

    assign done      = cur_valid_reg && m_tready && cur_last;
    assign slot_pop  = slot_valid_reg && (!cur_valid_reg || done);
    assign slot_free = !slot_valid_reg || slot_pop;

    // Holding slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_valid_reg <= 1'b0;
        else if (push)
            slot_valid_reg <= 1'b1;
        else if (slot_pop)
            slot_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg <= batch;
    end

    // Serialiser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (slot_pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (done)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (cur_valid_reg && m_tready)
            idx_reg <= idx_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (slot_pop)
            cur_reg <= slot_reg;
    end

    // Checks
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> slot_free)
        else $error("batch pushed into an occupied slot");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg < total_items))
        else $error("item index beyond batch");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("status item not last of its batch");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !slot_valid_reg) |=> !m_tvalid)
        else $error("output valid with no batch loaded");

endmodule

// ----- rtl/mp4_box_type_filter.sv -----
// Path: each input transfer's batch is registered in the holding slot, then in the serialiser,
// whose valid flag drives m_tvalid for its first result transfer.
// Throughput: one byte per cycle; a kept header leaves as 8 output transfers,
// paced by the single output port, and input stalls while two batches wait.
// Reset: drop types return to ftyp and moov, parsing restarts in the header phase.
// Top level of the MP4 box type filter: parser and result emitter.
// Depends on mbtf_pkg, mbtf_parser and mbtf_emitter.
module mp4_box_type_filter
    import mbtf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_packet
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] box_first, [10:9] packet_status
    output logic        m_tuser,   // [0] out_kind
    output logic        m_tlast    // last
);

    logic   accept;
    logic   push;
    logic   slot_free;
    batch_t batch;

    assign s_tready = slot_free;
    assign accept   = s_tvalid && slot_free;

    mbtf_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .in_byte       (s_tdata),
        .end_of_packet (s_tlast),
        .push          (push),
        .batch         (batch)
    );

    mbtf_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .batch     (batch),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- dv/mp4_box_type_filter_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for mp4_box_type_filter: a table of directed packets,
// then random box sequences under several drop-type settings and idling mixes.
// Depends on mbtf_pkg and the mp4_box_type_filter RTL.
module mp4_box_type_filter_tb;
    import mbtf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 30;

    // One expected result transfer
    typedef struct packed {
        logic [7:0] data;
        logic       kind;
        logic       first;
        status_t    status;
        logic       last;
    } result_t;

    // One directed stimulus row; status is typed in only on end-of-packet rows
    typedef struct packed {
        logic [7:0] data;
        logic       eop;
        logic       has_status;
        status_t    status;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = 32'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // [7:0] in_byte
    logic        s_tlast = 1'b0;    // end_of_packet
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] out_byte, [8] box_first, [10:9] packet_status
    logic        m_tuser;           // [0] out_kind
    logic        m_tlast;           // last

    // Typed status travelling with the byte on the bus
    logic        row_has_status = 1'b0;
    status_t     row_status = ST_OK;

    int          send_idle = 31;
    int          recv_idle = 70;
    int          mismatches = 0;
    int          live_bytes = 0;
    int          cycles = 0;
    logic        in_fire = 1'b0;

    // Filter model state
    logic [31:0] drop_a = TYPE_FTYP;
    logic [31:0] drop_b = TYPE_MOOV;
    phase_t      parse_ph = PH_HEADER;
    logic [63:0] hdr_hold = 64'd0;
    logic [3:0]  hdr_count = 4'd0;
    logic [31:0] body_left = 32'd0;
    logic        keep_box = 1'b0;
    status_t     pkt_status = ST_OK;

    result_t     pending_results[$];

    // Directed packets:
    //   8-byte moov box (dropped, no body), then a header cut after one byte
    //   all-ones size, kept type 0, packet ends as the header completes
    //   size 7 ftyp header, then a swallowed byte closing the packet
    row_t dir_rows [26] = '{
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h08, 1'b0, 1'b0, ST_OK},
        '{8'h6d, 1'b0, 1'b0, ST_OK}, '{8'h6f, 1'b0, 1'b0, ST_OK},
        '{8'h6f, 1'b0, 1'b0, ST_OK}, '{8'h76, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b1, 1'b1, ST_TRUNC_HEADER},
        '{8'hff, 1'b0, 1'b0, ST_OK}, '{8'hff, 1'b0, 1'b0, ST_OK},
        '{8'hff, 1'b0, 1'b0, ST_OK}, '{8'hff, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b1, 1'b1, ST_TRUNC_BODY},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h07, 1'b0, 1'b0, ST_OK},
        '{8'h66, 1'b0, 1'b0, ST_OK}, '{8'h74, 1'b0, 1'b0, ST_OK},
        '{8'h79, 1'b0, 1'b0, ST_OK}, '{8'h70, 1'b0, 1'b0, ST_OK},
        '{8'hff, 1'b1, 1'b1, ST_SMALL_SIZE}
    };

    mp4_box_type_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    // Run guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
        mismatches++;
    endtask

    // Works out the result transfers caused by one accepted byte
    task automatic filter_byte(input logic [7:0] b, input logic eop, input logic has_status,
                               input status_t typed_status);
        result_t     batch[$];
        result_t     item;
        logic [31:0] size;
        logic [31:0] btype;
        int          i;
        if (parse_ph == PH_HEADER)
        begin
            hdr_hold = {hdr_hold[55:0], b};
            hdr_count = hdr_count + 4'd1;
            if (hdr_count >= HDR_BYTES)
            begin
                size = hdr_hold[63:32];
                btype = hdr_hold[31:0];
                hdr_count = 4'd0;
                if (size < HDR_BYTES)
                begin
                    pkt_status = ST_SMALL_SIZE;
                    parse_ph = PH_STOP;
                end
                else
                begin
                    keep_box = (btype != drop_a) && (btype != drop_b);
                    // kept header leaves as a burst, first byte marked
                    if (keep_box)
                    begin
                        for (i = 0; i < 8; i++)
                        begin
                            item = '{hdr_hold[63 - 8 * i -: 8], 1'b0, (i == 0), ST_OK, 1'b0};
                            batch.push_back(item);
                        end
                    end
                    body_left = size - HDR_BYTES;
                    parse_ph = (body_left != 0) ? PH_BODY : PH_HEADER;
                end
                hdr_hold = 64'd0;
            end
            if (eop && pkt_status == ST_OK)
            begin
                if (parse_ph == PH_HEADER && hdr_count != 0)
                    pkt_status = ST_TRUNC_HEADER;
                else if (parse_ph == PH_BODY)
                    pkt_status = ST_TRUNC_BODY;
            end
        end
        else if (parse_ph == PH_BODY)
        begin
            if (keep_box)
            begin
                item = '{b, 1'b0, 1'b0, ST_OK, 1'b0};
                batch.push_back(item);
            end
            body_left = body_left - 32'd1;
            if (body_left == 0)
                parse_ph = PH_HEADER;
            else if (eop && pkt_status == ST_OK)
                pkt_status = ST_TRUNC_BODY;
        end
        // end of packet: status transfer, then a fresh start
        if (eop)
        begin
            item = '{8'd0, 1'b1, 1'b0, ST_OK, 1'b0};
            if (has_status)
                item.status = typed_status;
            else
                item.status = pkt_status;
            batch.push_back(item);
            parse_ph = PH_HEADER;
            hdr_hold = 64'd0;
            hdr_count = 4'd0;
            body_left = 32'd0;
            keep_box = 1'b0;
            pkt_status = ST_OK;
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            pending_results.push_back(batch[k]);
    endtask

    // Input and output monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DROP_FIRST)
                    drop_a = cfg_data;
                else
                    drop_b = cfg_data;
            end
            in_fire = s_tvalid && s_tready;
            if (in_fire)
            begin
                if (!(parse_ph == PH_STOP && !s_tlast))
                    live_bytes++;
                filter_byte(s_tdata, s_tlast, row_has_status, row_status);
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result", {15'd0, m_tuser, m_tdata}, 32'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[7:0] != want.data)
                        report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(want.data));
                    if (m_tuser != want.kind)
                        report_mismatch("out_kind", 32'(m_tuser), 32'(want.kind));
                    if (m_tdata[8] != want.first)
                        report_mismatch("box_first", 32'(m_tdata[8]), 32'(want.first));
                    if (m_tdata[10:9] != want.status)
                        report_mismatch("packet_status", 32'(m_tdata[10:9]),
                                        32'(want.status));
                    if (m_tlast != want.last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.last));
                    if (m_tdata[15:11] != 5'd0)
                        report_mismatch("tdata padding", 32'(m_tdata[15:11]), 32'd0);
                end
            end
        end
    end

    // One byte transfer; may first hold off until all results are out
    task automatic push_byte(input logic [7:0] b, input logic eop, input logic has_status,
                             input status_t st, input logic may_hold);
        if (may_hold && $urandom_range(49) == 0)
        begin
            s_tvalid <= 1'b0;
            do @(negedge clk); while (pending_results.size() != 0);
        end
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eop;
        row_has_status <= has_status;
        row_status <= st;
        do @(negedge clk); while (!in_fire);
    endtask

    // Stop sending and let every expected result drain
    task automatic settle(input int extra);
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic program_drop_types(input logic [31:0] first_type,
                                      input logic [31:0] second_type);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DROP_FIRST;
        cfg_data <= first_type;
        @(negedge clk);
        cfg_index <= CFG_DROP_SECOND;
        cfg_data <= second_type;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random packet: mostly well-formed box sequences, sometimes cut short,
    // sometimes plain noise
    task automatic send_random_packet();
        logic [7:0]  pkt[$];
        logic [7:0]  rb;
        logic [31:0] size;
        logic [31:0] btype;
        int          nbox;
        int          body_len;
        int          cut;
        int          k;
        int          j;
        int          pick;
        if ($urandom_range(99) < 10)
        begin
            repeat ($urandom_range(12, 1))
            begin
                rb = 8'($urandom_range(255));
                pkt.push_back(rb);
            end
        end
        else
        begin
            nbox = $urandom_range(3, 1);
            for (k = 0; k < nbox; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    size = $urandom_range(7, 0);
                else if (pick < 13)
                    size = {24'hff_ffff, 8'h00} | $urandom_range(255);
                else
                    size = $urandom_range(20, 8);
                pick = $urandom_range(99);
                if (pick < 30)
                    btype = drop_a;
                else if (pick < 55)
                    btype = drop_b;
                else if (pick < 70)
                    btype = drop_a ^ (32'd1 << $urandom_range(31));
                else
                    btype = $urandom();
                for (j = 3; j >= 0; j--)
                    pkt.push_back(size[8 * j +: 8]);
                for (j = 3; j >= 0; j--)
                    pkt.push_back(btype[8 * j +: 8]);
                body_len = 0;
                if (size > 32'd40)
                    body_len = $urandom_range(12);
                else if (size >= HDR_BYTES)
                    body_len = size - HDR_BYTES;
                repeat (body_len)
                begin
                    rb = 8'($urandom_range(255));
                    pkt.push_back(rb);
                end
            end
        end
        // about a third of the packets with more than one byte are cut short at a random point
        cut = pkt.size();
        if (cut > 1 && $urandom_range(99) < 35)
            cut = $urandom_range(cut - 1, 1);
        for (j = 0; j < cut; j++)
            push_byte(pkt[j], (j == cut - 1), 1'b0, ST_OK, 1'b1);
    endtask

    // Main sequence
    initial
    begin
        int          p;
        int          target;
        logic [31:0] r;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at reset drop types
        foreach (dir_rows[i])
            push_byte(dir_rows[i].data, dir_rows[i].eop, dir_rows[i].has_status,
                      dir_rows[i].status, 1'b0);
        settle(6);

        target = live_bytes;
        for (p = 0; p < 6; p++)
        begin
            case (p)
                1: program_drop_types(32'd0, 32'hffff_ffff);
                2: program_drop_types(32'hffff_ffff, 32'd0);
                3: program_drop_types($urandom(), $urandom());
                4:
                begin
                    r = $urandom();
                    program_drop_types(r, r);
                end
                5: program_drop_types(TYPE_FTYP, TYPE_MOOV);
                default: ;
            endcase
            if (p < 2)
            begin
                send_idle = 31;
                recv_idle = 70;
            end
            else if (p < 4)
            begin
                send_idle = 70;
                recv_idle = 31;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            target += ITEMS_PER_PHASE;
            while (live_bytes < target)
                send_random_packet();
            settle(6);
        end

        settle(20);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mbtf_pkg.sv
rtl/mbtf_parser.sv
rtl/mbtf_emitter.sv
rtl/mp4_box_type_filter.sv
dv/mp4_box_type_filter_tb.sv
